[sv/rgb_led_column_pwm_scanner_assert.svh]
// Assertion macros shared by the scanner RTL.
`ifndef RGB_LED_COLUMN_PWM_SCANNER_ASSERT_SVH
`define RGB_LED_COLUMN_PWM_SCANNER_ASSERT_SVH

// Same-cycle implication under reset.
`define RLCPS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define RLCPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/rlcps_pkg.sv]
`timescale 1ns / 1ps

package rlcps_pkg;

    localparam int FUNC_W      = 2;
    localparam int COL_FIELD_W = 4;
    localparam int ROW_FIELD_W = 3;
    localparam int VALUE_W     = 8;
    localparam int ROW_BYTE_W  = 8;
    localparam int DELAY_W     = 10;

    localparam logic [DELAY_W-1:0]    DELAY_RESET = 10'd62;
    localparam logic [ROW_BYTE_W-1:0] ALL_OFF     = 8'hFF;

    // input function codes
    localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TRIGGER = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd2;

    // what an item does to the row drive
    localparam logic [1:0] KIND_HOLD = 2'd0;
    localparam logic [1:0] KIND_OFF  = 2'd1;
    localparam logic [1:0] KIND_SHOW = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic       sweeping;
    } step_t;

endpackage

[sv/rlcps_ctrl.sv]
`timescale 1ns / 1ps
`include "rgb_led_column_pwm_scanner_assert.svh"

module rlcps_ctrl #(
    parameter int COLUMNS = 16,
    parameter int LEVELS  = 8,
    localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1,
    localparam int SW = $clog2(LEVELS)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [rlcps_pkg::FUNC_W-1:0]      func,
    input  logic                              cfg_we,
    input  logic [rlcps_pkg::DELAY_W-1:0]     cfg_data,
    output rlcps_pkg::step_t                  step,
    output logic [SW-1:0]                     slot,
    output logic [CW-1:0]                     rd_col
);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_DELAY  = 2'd1;
    localparam logic [1:0] PH_SWEEP  = 2'd2;
    localparam logic [1:0] PH_FINISH = 2'd3;

    logic [1:0]                       phase_reg, phase_next;
    logic [rlcps_pkg::DELAY_W-1:0]    delay_count_reg, delay_count_next;
    logic [rlcps_pkg::DELAY_W-1:0]    start_delay_reg;
    logic [CW-1:0]                    column_step_reg, column_step_next;
    logic [SW-1:0]                    slot_index_reg, slot_index_next;
    logic [1:0]                       kind;
    logic [rlcps_pkg::DELAY_W-1:0]    delay_dec;

    always_comb
    begin
        phase_next       = phase_reg;
        delay_count_next = delay_count_reg;
        column_step_next = column_step_reg;
        slot_index_next  = slot_index_reg;
        kind             = rlcps_pkg::KIND_HOLD;
        delay_dec        = delay_count_reg;
        unique case (func)
            rlcps_pkg::FUNC_WRITE:
            begin
                kind = rlcps_pkg::KIND_HOLD;
            end
            rlcps_pkg::FUNC_TRIGGER:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    kind             = rlcps_pkg::KIND_OFF;
                    column_step_next = '0;
                    slot_index_next  = '0;
                    delay_count_next = start_delay_reg;
                    phase_next       = (start_delay_reg == '0) ? PH_SWEEP : PH_DELAY;
                end
            end
            rlcps_pkg::FUNC_TICK:
            begin
                kind = rlcps_pkg::KIND_OFF;
                unique case (phase_reg)
                    PH_DELAY:
                    begin
                        if (delay_count_reg != '0)
                        begin
                            delay_dec = delay_count_reg - 1'b1;
                        end
                        delay_count_next = delay_dec;
                        if (delay_dec == '0)
                        begin
                            phase_next = PH_SWEEP;
                        end
                    end
                    PH_SWEEP:
                    begin
                        kind = rlcps_pkg::KIND_SHOW;
                        if (slot_index_reg == SW'(LEVELS - 1))
                        begin
                            slot_index_next = '0;
                            if (column_step_reg == CW'(COLUMNS - 1))
                            begin
                                column_step_next = '0;
                                phase_next       = PH_FINISH;
                            end
                            else
                            begin
                                column_step_next = column_step_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            slot_index_next = slot_index_reg + 1'b1;
                        end
                    end
                    PH_FINISH:
                    begin
                        phase_next = PH_IDLE;
                    end
                    PH_IDLE:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            default:
            begin
                kind = rlcps_pkg::KIND_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            delay_count_reg <= '0;
            column_step_reg <= '0;
            slot_index_reg  <= '0;
            start_delay_reg <= rlcps_pkg::DELAY_RESET;
        end
        else
        begin
            if (accept)
            begin
                phase_reg       <= phase_next;
                delay_count_reg <= delay_count_next;
                column_step_reg <= column_step_next;
                slot_index_reg  <= slot_index_next;
            end
            if (cfg_we)
            begin
                start_delay_reg <= cfg_data;
            end
        end
    end

    assign step.kind     = kind;
    assign step.sweeping = (phase_next != PH_IDLE);
    assign slot          = slot_index_reg;
    assign rd_col        = CW'(COLUMNS - 1) - column_step_reg;

    `RLCPS_ASSERT_IMP(a_idle_counters_zero, clk, rst_n, phase_reg == PH_IDLE, column_step_reg == '0 && slot_index_reg == '0, "idle with nonzero scan counters")
    `RLCPS_ASSERT_IMP(a_delay_nonzero, clk, rst_n, phase_reg == PH_DELAY, delay_count_reg != '0, "delay phase with zero count")
    `RLCPS_ASSERT_NEXT(a_last_slot_finish, clk, rst_n, accept && func == rlcps_pkg::FUNC_TICK && phase_reg == PH_SWEEP && slot_index_reg == SW'(LEVELS - 1) && column_step_reg == CW'(COLUMNS - 1), phase_reg == PH_FINISH, "last slot did not enter finish")

endmodule

[sv/rlcps_frame.sv]
`timescale 1ns / 1ps

module rlcps_frame #(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 8,
    parameter int LEVELS  = 8,
    localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1,
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1,
    localparam int LW = $clog2(LEVELS)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [CW-1:0]                     wr_col,
    input  logic [RW-1:0]                     wr_row,
    input  logic [rlcps_pkg::VALUE_W-1:0]     red_value,
    input  logic [rlcps_pkg::VALUE_W-1:0]     green_value,
    input  logic [rlcps_pkg::VALUE_W-1:0]     blue_value,
    input  logic                              rd_en,
    input  logic [CW-1:0]                     rd_col,
    output logic [ROWS-1:0][2:0][LW-1:0]      rd_data,
    output logic                              clearing
);

    logic [ROWS-1:0][2:0][LW-1:0] mem [COLUMNS];
    logic [ROWS-1:0][2:0][LW-1:0] rd_data_reg;
    logic [2:0][LW-1:0]           wr_pix;
    logic                         clear_reg;
    logic [CW-1:0]                clear_addr_reg;

    // level = value * LEVELS / 256
    assign wr_pix[0] = LW'((16'(red_value)   * 16'(LEVELS)) >> 8);
    assign wr_pix[1] = LW'((16'(green_value) * 16'(LEVELS)) >> 8);
    assign wr_pix[2] = LW'((16'(blue_value)  * 16'(LEVELS)) >> 8);

    // zero one column per cycle after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clear_reg)
        begin
            if (clear_addr_reg == CW'(COLUMNS - 1))
            begin
                clear_reg <= 1'b0;
            end
            else
            begin
                clear_addr_reg <= clear_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_reg)
        begin
            mem[clear_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_col][wr_row] <= wr_pix;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_col];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clear_reg;

endmodule

[sv/rlcps_drive.sv]
`timescale 1ns / 1ps

module rlcps_drive #(
    parameter int ROWS   = 8,
    parameter int LEVELS = 8,
    localparam int LW = $clog2(LEVELS)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  rlcps_pkg::step_t                     step,
    input  logic [LW-1:0]                        slot,
    input  logic [ROWS-1:0][2:0][LW-1:0]         rd_data,
    input  logic                                 out_stall,
    output logic                                 s1_ready,
    output logic                                 out_valid,
    output logic [rlcps_pkg::ROW_BYTE_W-1:0]     red_rows,
    output logic [rlcps_pkg::ROW_BYTE_W-1:0]     green_rows,
    output logic [rlcps_pkg::ROW_BYTE_W-1:0]     blue_rows,
    output logic                                 sweeping
);

    logic                                        s1_valid_reg;
    rlcps_pkg::step_t                            s1_step_reg;
    logic [LW-1:0]                               s1_slot_reg;
    logic                                        out_valid_reg;
    logic [2:0][rlcps_pkg::ROW_BYTE_W-1:0]       rows_reg, rows_next;
    logic                                        sweeping_reg;
    logic [2:0][rlcps_pkg::ROW_BYTE_W-1:0]       show_rows;
    logic                                        out_take;
    logic                                        s1_move;

    assign out_take = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_take;
    assign s1_ready = !s1_valid_reg || out_take;

    // light a row colour when its level exceeds the slot
    always_comb
    begin
        show_rows = {3{rlcps_pkg::ALL_OFF}};
        for (int r = 0; r < ROWS; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (rd_data[r][c] > s1_slot_reg)
                begin
                    show_rows[c][r] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        unique case (s1_step_reg.kind)
            rlcps_pkg::KIND_SHOW: rows_next = show_rows;
            rlcps_pkg::KIND_OFF:  rows_next = {3{rlcps_pkg::ALL_OFF}};
            default:              rows_next = rows_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rows_reg      <= {3{rlcps_pkg::ALL_OFF}};
            sweeping_reg  <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= load;
            end
            if (out_take)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_move)
            begin
                rows_reg     <= rows_next;
                sweeping_reg <= s1_step_reg.sweeping;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_step_reg <= step;
            s1_slot_reg <= slot;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_rows   = rows_reg[0];
    assign green_rows = rows_reg[1];
    assign blue_rows  = rows_reg[2];
    assign sweeping   = sweeping_reg;

endmodule

[sv/rgb_led_column_pwm_scanner.sv]
// RGB LED column scanner with PWM row drive.
// Input channel (in_valid / in_stall) carries one item per accepted edge:
// func selects a pixel write, a sweep trigger or one slot tick. Each item
// yields exactly one output item on the out_valid / out_stall channel with
// the active-low red, green and blue row bytes and the sweeping flag, all
// as they stand after that item.
// An accepted item passes through the input stage with the frame read,
// then the output register. Throughput is one item per cycle while no
// stall or frame clear holds the input, set by the frame store read and
// the per-column level compare; the output register lets a new item
// enter while a result still waits.
// When the receiver stalls, the output holds and in_stall rises once the
// middle stage is also full.
// Reset: LEDs off, idle, start delay 62 ticks. The frame store is then
// zeroed one column per cycle while in_stall is held high.
// cfg_data sets the start delay; cfg_ready is always high, write only
// while the block is idle.
`timescale 1ns / 1ps
`include "rgb_led_column_pwm_scanner_assert.svh"

module rgb_led_column_pwm_scanner #(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 8,
    parameter int LEVELS  = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [rlcps_pkg::FUNC_W-1:0]          func,
    input  logic [rlcps_pkg::COL_FIELD_W-1:0]     pixel_column,
    input  logic [rlcps_pkg::ROW_FIELD_W-1:0]     pixel_row,
    input  logic [rlcps_pkg::VALUE_W-1:0]         red_value,
    input  logic [rlcps_pkg::VALUE_W-1:0]         green_value,
    input  logic [rlcps_pkg::VALUE_W-1:0]         blue_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [rlcps_pkg::ROW_BYTE_W-1:0]      red_rows,
    output logic [rlcps_pkg::ROW_BYTE_W-1:0]      green_rows,
    output logic [rlcps_pkg::ROW_BYTE_W-1:0]      blue_rows,
    output logic                                  sweeping,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rlcps_pkg::DELAY_W-1:0]         cfg_data
);

    localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LW = $clog2(LEVELS);

    logic                              accept;
    logic                              clearing;
    logic                              s1_ready;
    logic                              pix_in_range;
    logic                              wr_en;
    rlcps_pkg::step_t                  step;
    logic [LW-1:0]                     slot;
    logic [CW-1:0]                     rd_col;
    logic [ROWS-1:0][2:0][LW-1:0]      rd_data;

    // hold off items while the frame store clears or the pipe is full
    assign in_stall  = clearing || !s1_ready;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // drop pixel writes outside the frame
    assign pix_in_range = (int'(pixel_column) < COLUMNS) && (int'(pixel_row) < ROWS);
    assign wr_en        = accept && (func == rlcps_pkg::FUNC_WRITE) && pix_in_range;

    rlcps_ctrl #(
        .COLUMNS (COLUMNS),
        .LEVELS  (LEVELS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .func     (func),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .step     (step),
        .slot     (slot),
        .rd_col   (rd_col)
    );

    rlcps_frame #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .LEVELS  (LEVELS)
    ) u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_col      (CW'(pixel_column)),
        .wr_row      (RW'(pixel_row)),
        .red_value   (red_value),
        .green_value (green_value),
        .blue_value  (blue_value),
        .rd_en       (accept),
        .rd_col      (rd_col),
        .rd_data     (rd_data),
        .clearing    (clearing)
    );

    rlcps_drive #(
        .ROWS   (ROWS),
        .LEVELS (LEVELS)
    ) u_drive (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .step       (step),
        .slot       (slot),
        .rd_data    (rd_data),
        .out_stall  (out_stall),
        .s1_ready   (s1_ready),
        .out_valid  (out_valid),
        .red_rows   (red_rows),
        .green_rows (green_rows),
        .blue_rows  (blue_rows),
        .sweeping   (sweeping)
    );

    `RLCPS_ASSERT_IMP(a_clear_stalls, clk, rst_n, clearing, in_stall, "item accepted during frame clear")
    `RLCPS_ASSERT_IMP(a_clear_no_output, clk, rst_n, clearing, !out_valid, "output item during frame clear")
    `RLCPS_ASSERT_IMP(a_idle_leds_off, clk, rst_n, out_valid && !sweeping, red_rows == rlcps_pkg::ALL_OFF && green_rows == rlcps_pkg::ALL_OFF && blue_rows == rlcps_pkg::ALL_OFF, "LEDs lit while idle")

endmodule
